// File: src/sbi_pkg.sv
// ----------------------------------------------------------------------------
// sbi_pkg
// Shared types and codes of the sparse block bitmap index engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sbi_pkg;

  localparam int BLOCK_COUNT_DEF = 16;
  localparam int BLOCK_BITS_DEF  = 1024;

  localparam int ID_W     = 14;
  localparam int BLOCK_W  = 5;
  localparam int LIMIT_W  = 7;
  localparam int CNT_W    = 15;
  localparam int WORD_W   = 64;
  localparam int BITSEL_W = 6;

  localparam logic [LIMIT_W-1:0] MAX_RESULTS = LIMIT_W'(64);
  localparam logic [CNT_W-1:0]   HITS_MAX    = 15'h7fff;

  localparam logic [WORD_W-1:0] WORD_ONES = {8{8'hff}};
  localparam logic [WORD_W-1:0] WORD_ZERO = {8{8'h0}};

  localparam logic [2:0] ACT_LOAD   = 3'd0;
  localparam logic [2:0] ACT_UNLOAD = 3'd1;
  localparam logic [2:0] ACT_SET    = 3'd2;
  localparam logic [2:0] ACT_SCAN   = 3'd3;
  localparam logic [2:0] ACT_FILTER = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_RANGE   = 2'd1;
  localparam logic [1:0] ST_PRESENT = 2'd2;
  localparam logic [1:0] ST_ABSENT  = 2'd3;

  typedef struct packed {
    logic [2:0]         action;
    logic [BLOCK_W-1:0] block;
    logic               fill_value;
    logic [ID_W-1:0]    id;
    logic               bit_value;
    logic [LIMIT_W-1:0] scan_limit;
    logic               run_start;
    logic [CNT_W-1:0]   skip;
    logic [CNT_W-1:0]   filter_limit;
  } sbi_in_t;

  typedef struct packed {
    logic [1:0]      status;
    logic            found;
    logic [ID_W-1:0] result_id;
    logic            last;
  } sbi_out_t;

endpackage

`default_nettype wire

// File: src/sbi_ram.sv
// ----------------------------------------------------------------------------
// sbi_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sbi_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: src/sbi_lsb.sv
// ----------------------------------------------------------------------------
// sbi_lsb
// Lowest set bit of a bitmap word: its index and the word with it cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sbi_lsb (
  input  wire logic [63:0] data_in,
  output logic      [5:0]  idx,
  output logic      [63:0] rest
);

  import sbi_pkg::*;

  logic [WORD_W-1:0] iso;

  assign iso  = data_in & (~data_in + WORD_W'(1));
  assign rest = data_in & (data_in - WORD_W'(1));

  always_comb begin
    idx = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (iso[i]) begin
        idx = idx | BITSEL_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

// File: src/sbi_core.sv
// ----------------------------------------------------------------------------
// sbi_core
// Sequencer of the index: decode, block fill sweeps, read-modify-write of
// bitmap words, filter counters and the word-by-word scan walk.
// ----------------------------------------------------------------------------
`default_nettype none

module sbi_core #(
  parameter int BLOCK_COUNT = 16,
  parameter int BLOCK_BITS  = 1024,
  parameter int WA          = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire sbi_pkg::sbi_in_t in_data,
  output logic                  out_valid,
  output sbi_pkg::sbi_out_t     out_data,
  output logic                  ram_we,
  output logic [WA-1:0]         ram_waddr,
  output logic [63:0]           ram_wdata,
  output logic [WA-1:0]         ram_raddr,
  input  wire logic [63:0]      ram_rdata
);

  import sbi_pkg::*;

  localparam int WPB       = BLOCK_BITS / 64;
  localparam int TOTAL_IDS = BLOCK_COUNT * BLOCK_BITS;
  localparam int BW        = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
  localparam int WIW       = (WPB > 1) ? $clog2(WPB) : 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_FILL,
    S_RMW,
    S_FILT,
    S_SCAN_ADDR,
    S_SCAN_LOAD,
    S_SCAN_EMIT,
    S_SCAN_END
  } state_t;

  state_t                 state_r, state_nxt;
  sbi_in_t                item_r, item_nxt;
  logic                   range_r, range_nxt;
  logic [BW-1:0]          blk_r, blk_nxt;
  logic [WIW-1:0]         wi_r, wi_nxt;
  logic [BLOCK_COUNT-1:0] present_r, present_nxt;
  logic [CNT_W-1:0]       hits_r, hits_nxt;
  logic [CNT_W-1:0]       passed_r, passed_nxt;
  logic                   fill_r, fill_nxt;
  logic                   setfill_r, setfill_nxt;
  logic                   first_r, first_nxt;
  logic [WORD_W-1:0]      work_r, work_nxt;
  logic                   pend_valid_r, pend_valid_nxt;
  logic [ID_W-1:0]        pend_id_r, pend_id_nxt;
  logic [LIMIT_W-1:0]     count_r, count_nxt;
  logic [LIMIT_W-1:0]     limit_r, limit_nxt;
  logic                   out_valid_r, out_valid_nxt;
  sbi_out_t               out_data_r, out_data_nxt;

  logic [BW-1:0]     id_blk;
  logic [WA-1:0]     cur_addr;
  logic [WA-1:0]     id_addr;
  logic [WORD_W-1:0] bit_mask;
  logic [WORD_W-1:0] fill_word;
  logic              blk_present;
  logic              blk_last;
  logic              wi_last;
  logic              hit;
  logic [5:0]        lsb_idx;
  logic [WORD_W-1:0] lsb_rest;

  sbi_lsb u_lsb (
    .data_in (work_r),
    .idx     (lsb_idx),
    .rest    (lsb_rest)
  );

  always_comb begin
    id_blk = '0;
    for (int b = 1; b < BLOCK_COUNT; b++) begin
      if (32'(in_data.id) >= b * BLOCK_BITS) begin
        id_blk = BW'(b);
      end
    end
  end

  assign cur_addr    = WA'(32'(blk_r) * WPB + 32'(wi_r));
  assign id_addr     = WA'(32'(item_r.id[ID_W-1:6]));
  assign bit_mask    = WORD_W'(1) << item_r.id[5:0];
  assign blk_present = present_r[blk_r];
  assign blk_last    = (blk_r == BW'(BLOCK_COUNT - 1));
  assign wi_last     = (wi_r == WIW'(WPB - 1));
  assign hit         = ram_rdata[item_r.id[5:0]];
  assign fill_word   = (setfill_r && item_r.bit_value && (cur_addr == id_addr)) ? bit_mask :
                       (fill_r ? WORD_ONES : WORD_ZERO);

  assign ram_we    = (state_r == S_FILL) || (state_r == S_RMW);
  assign ram_waddr = (state_r == S_FILL) ? cur_addr : id_addr;
  assign ram_wdata = (state_r == S_FILL) ? fill_word :
                     (item_r.bit_value ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask));
  assign ram_raddr = (state_r == S_SCAN_ADDR) ? cur_addr : id_addr;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    range_nxt      = range_r;
    blk_nxt        = blk_r;
    wi_nxt         = wi_r;
    present_nxt    = present_r;
    hits_nxt       = hits_r;
    passed_nxt     = passed_r;
    fill_nxt       = fill_r;
    setfill_nxt    = setfill_r;
    first_nxt      = first_r;
    work_nxt       = work_r;
    pend_valid_nxt = pend_valid_r;
    pend_id_nxt    = pend_id_r;
    count_nxt      = count_r;
    limit_nxt      = limit_r;
    out_valid_nxt  = 1'b0;
    out_data_nxt   = out_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt  = in_data;
          state_nxt = S_EXEC;
          if ((in_data.action == ACT_LOAD) || (in_data.action == ACT_UNLOAD)) begin
            range_nxt = (32'(in_data.block) >= BLOCK_COUNT);
            blk_nxt   = BW'(in_data.block);
          end else begin
            range_nxt = (32'(in_data.id) >= TOTAL_IDS);
            blk_nxt   = id_blk;
          end
        end
      end

      S_EXEC: begin
        out_data_nxt = '{status: ST_OK, found: 1'b0, result_id: '0, last: 1'b1};
        wi_nxt       = '0;
        state_nxt    = S_IDLE;
        unique case (item_r.action)
          ACT_LOAD: begin
            if (range_r) begin
              out_data_nxt.status = ST_RANGE;
              out_valid_nxt       = 1'b1;
            end else if (blk_present) begin
              out_data_nxt.status = ST_PRESENT;
              out_valid_nxt       = 1'b1;
            end else begin
              fill_nxt    = item_r.fill_value;
              setfill_nxt = 1'b0;
              state_nxt   = S_FILL;
            end
          end
          ACT_UNLOAD: begin
            out_valid_nxt = 1'b1;
            if (range_r) begin
              out_data_nxt.status = ST_RANGE;
            end else if (!blk_present) begin
              out_data_nxt.status = ST_ABSENT;
            end else begin
              present_nxt[blk_r] = 1'b0;
            end
          end
          ACT_SET: begin
            if (range_r) begin
              out_data_nxt.status = ST_RANGE;
              out_valid_nxt       = 1'b1;
            end else if (!blk_present) begin
              fill_nxt    = 1'b0;
              setfill_nxt = 1'b1;
              state_nxt   = S_FILL;
            end else begin
              state_nxt = S_RMW;
            end
          end
          ACT_SCAN: begin
            limit_nxt      = (item_r.scan_limit > MAX_RESULTS) ? MAX_RESULTS
                                                               : item_r.scan_limit;
            count_nxt      = '0;
            pend_valid_nxt = 1'b0;
            first_nxt      = 1'b1;
            wi_nxt         = WIW'(32'(item_r.id[ID_W-1:6]) - 32'(blk_r) * WPB);
            if (range_r) begin
              out_data_nxt.status = ST_RANGE;
              out_valid_nxt       = 1'b1;
            end else if (item_r.scan_limit == '0) begin
              out_valid_nxt = 1'b1;
            end else begin
              state_nxt = S_SCAN_ADDR;
            end
          end
          ACT_FILTER: begin
            if (item_r.run_start) begin
              hits_nxt   = '0;
              passed_nxt = '0;
            end
            if (range_r) begin
              out_data_nxt.status = ST_RANGE;
              out_valid_nxt       = 1'b1;
            end else if (!blk_present) begin
              out_valid_nxt = 1'b1;
            end else begin
              state_nxt = S_FILT;
            end
          end
          default: begin
            out_valid_nxt = 1'b1;
          end
        endcase
      end

      S_FILL: begin
        wi_nxt = wi_r + WIW'(1);
        if (wi_last) begin
          present_nxt[blk_r] = 1'b1;
          out_data_nxt  = '{status: ST_OK, found: 1'b0, result_id: '0, last: 1'b1};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      S_RMW: begin
        out_data_nxt  = '{status: ST_OK, found: 1'b0, result_id: '0, last: 1'b1};
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      S_FILT: begin
        out_data_nxt  = '{status: ST_OK, found: 1'b0, result_id: '0, last: 1'b1};
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (hit) begin
          if ((hits_r >= item_r.skip) && (passed_r < item_r.filter_limit)) begin
            out_data_nxt.found     = 1'b1;
            out_data_nxt.result_id = item_r.id;
            passed_nxt             = passed_r + CNT_W'(1);
          end
          if (hits_r < HITS_MAX) begin
            hits_nxt = hits_r + CNT_W'(1);
          end
        end
      end

      S_SCAN_ADDR: begin
        if (blk_present) begin
          state_nxt = S_SCAN_LOAD;
        end else begin
          first_nxt = 1'b0;
          wi_nxt    = '0;
          if (blk_last) begin
            state_nxt = S_SCAN_END;
          end else begin
            blk_nxt = blk_r + BW'(1);
          end
        end
      end

      S_SCAN_LOAD: begin
        work_nxt  = first_r ? (ram_rdata & (WORD_ONES << item_r.id[5:0])) : ram_rdata;
        first_nxt = 1'b0;
        state_nxt = S_SCAN_EMIT;
      end

      S_SCAN_EMIT: begin
        if (work_r == WORD_ZERO) begin
          if (wi_last) begin
            wi_nxt = '0;
            if (blk_last) begin
              state_nxt = S_SCAN_END;
            end else begin
              blk_nxt   = blk_r + BW'(1);
              state_nxt = S_SCAN_ADDR;
            end
          end else begin
            wi_nxt    = wi_r + WIW'(1);
            state_nxt = S_SCAN_ADDR;
          end
        end else begin
          work_nxt = lsb_rest;
          if (pend_valid_r) begin
            out_data_nxt  = '{status: ST_OK, found: 1'b1, result_id: pend_id_r, last: 1'b0};
            out_valid_nxt = 1'b1;
          end
          pend_valid_nxt = 1'b1;
          pend_id_nxt    = ID_W'({cur_addr, lsb_idx});
          count_nxt      = count_r + LIMIT_W'(1);
          if ((count_r + LIMIT_W'(1)) == limit_r) begin
            state_nxt = S_SCAN_END;
          end
        end
      end

      S_SCAN_END: begin
        out_valid_nxt = 1'b1;
        if (pend_valid_r) begin
          out_data_nxt = '{status: ST_OK, found: 1'b1, result_id: pend_id_r, last: 1'b1};
        end else begin
          out_data_nxt = '{status: ST_OK, found: 1'b0, result_id: '0, last: 1'b1};
        end
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      present_r    <= '0;
      hits_r       <= '0;
      passed_r     <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      present_r    <= present_nxt;
      hits_r       <= hits_nxt;
      passed_r     <= passed_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    range_r    <= range_nxt;
    blk_r      <= blk_nxt;
    wi_r       <= wi_nxt;
    fill_r     <= fill_nxt;
    setfill_r  <= setfill_nxt;
    first_r    <= first_nxt;
    work_r     <= work_nxt;
    pend_id_r  <= pend_id_nxt;
    count_r    <= count_nxt;
    limit_r    <= limit_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

// File: src/sparse_bitmap_index_engine.sv
// ----------------------------------------------------------------------------
// sparse_bitmap_index_engine
// Bitmap of ids in fixed blocks with present flags: load, unload, set bit,
// ordered scan of set ids and a skip/limit filter over streamed ids.
//
//   channel   ports                  transfer
//   -------   --------------------   ---------------------------------------
//   input     start, busy, in_data   start high and busy low at clock edge
//   result    out_valid, out_data    out_valid high for one cycle, no stall
//
// Unload, load of a present block, filter on an absent block, unknown
// actions and out-of-range items: result registered from the decode step.
// Set on a present block and filter on a present block: decode, then one
// word read of the bitmap RAM (read-modify-write for set). Load, or set on
// an absent block: decode, then one RAM write per word of the block.
// Scan: address, load and emit steps per word of a present block, one
// address step per absent block, one emit per id; bound by one RAM read port.
// Reset clears present flags and filter counters; the bitmap RAM is not
// cleared. Results are never held back.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_bitmap_index_engine #(
  parameter int BLOCK_COUNT = sbi_pkg::BLOCK_COUNT_DEF,
  parameter int BLOCK_BITS  = sbi_pkg::BLOCK_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire sbi_pkg::sbi_in_t in_data,
  output logic                  out_valid,
  output sbi_pkg::sbi_out_t     out_data
);

  import sbi_pkg::*;

  localparam int TOTAL_WORDS = BLOCK_COUNT * (BLOCK_BITS / 64);
  localparam int WA          = (TOTAL_WORDS > 1) ? $clog2(TOTAL_WORDS) : 1;

  logic              ram_we;
  logic [WA-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WA-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  sbi_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TOTAL_WORDS),
    .AW    (WA)
  ) u_bitmap_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  sbi_core #(
    .BLOCK_COUNT (BLOCK_COUNT),
    .BLOCK_BITS  (BLOCK_BITS),
    .WA          (WA)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

endmodule

`default_nettype wire
